// ===== hw/rtl/rigid_body_derived_data_defines.svh =====
// assertion macros shared by the rigid body derived data modules
`ifndef RIGID_BODY_DERIVED_DATA_DEFINES_SVH
`define RIGID_BODY_DERIVED_DATA_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define RBDD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbdd check failed");

// condition holds in the cycle after the trigger
`define RBDD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbdd check failed");

`endif

// ===== hw/rtl/rbdd_pkg.sv =====
// rbdd_pkg: shared types, widths, codes and fixed-point helpers
`timescale 1ns / 1ps

package rbdd_pkg;

	localparam int FRAC    = 15;
	localparam int RQ_W    = 35;
	localparam int PT_W    = 48;
	localparam int ACC_T_W = 50;
	localparam int T_W     = ACC_T_W - FRAC;
	localparam int PW_W    = 51;
	localparam int ACC_W_W = 53;
	localparam int SH_W_W  = ACC_W_W - FRAC;

	typedef logic signed [15:0] q15_t;
	typedef logic signed [31:0] q16_t;
	typedef logic signed [31:0] qprod_t;
	typedef logic signed [RQ_W-1:0] rq_t;
	typedef logic signed [PT_W-1:0] pt_t;
	typedef logic signed [T_W-1:0] tval_t;
	typedef logic signed [PW_W-1:0] pw_t;

	localparam rq_t  ONE_Q30  = RQ_W'(2 ** 30);
	localparam q15_t Q15_MAX  = 16'sh7FFF;
	localparam q15_t Q15_MIN  = 16'sh8000;
	localparam q16_t Q16_MAX  = 32'sh7FFF_FFFF;
	localparam q16_t Q16_MIN  = 32'sh8000_0000;
	localparam q16_t Q16_ONE  = 32'sh0001_0000;
	localparam q16_t Q16_ZERO = 32'sh0000_0000;

	localparam logic [1:0] ROW_FIRST = 2'd0;
	localparam logic [1:0] ROW_LAST  = 2'd2;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;

	typedef enum logic [2:0] {
		REG_XX = 3'd0,
		REG_YY = 3'd1,
		REG_ZZ = 3'd2,
		REG_XY = 3'd3,
		REG_XZ = 3'd4,
		REG_YZ = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		q15_t quat_w;
		q15_t quat_x;
		q15_t quat_y;
		q15_t quat_z;
		q16_t pos_x;
		q16_t pos_y;
		q16_t pos_z;
	} body_t;

	typedef struct packed {
		logic [1:0] row_index;
		q15_t       rot_c0;
		q15_t       rot_c1;
		q15_t       rot_c2;
		q16_t       translation;
		q16_t       world_c0;
		q16_t       world_c1;
		q16_t       world_c2;
		logic       last_row;
	} row_t;

	typedef logic [2:0][15:0] rrow_t;
	typedef logic [2:0][2:0][15:0] rmat_t;
	typedef logic [2:0][31:0] vec3_t;
	typedef logic [2:0][2:0][31:0] imat_t;

	typedef struct packed {
		rmat_t rmat;
		vec3_t pos;
	} rot_item_t;

	typedef struct packed {
		logic [1:0] idx;
		rrow_t      rrow;
		rmat_t      rmat;
		q16_t       trans;
	} row_job_t;

	function automatic qprod_t mul_q(input q15_t a, input q15_t b);
		return 32'(a) * 32'(b);
	endfunction

	// Q.30 value -> Q1.15, add half then floor, saturate
	function automatic q15_t sat_q15(input rq_t v);
		rq_t a;
		logic signed [RQ_W-FRAC-1:0] s;
		a = v + RQ_W'(2 ** (FRAC - 1));
		s = a[RQ_W-1:FRAC];
		if (&s[RQ_W-FRAC-1:15] || ~|s[RQ_W-FRAC-1:15])
			return s[15:0];
		return s[RQ_W-FRAC-1] ? Q15_MIN : Q15_MAX;
	endfunction

	function automatic q15_t rot_diag(input qprod_t pa, input qprod_t pb);
		rq_t a;
		rq_t b;
		a = RQ_W'(pa);
		b = RQ_W'(pb);
		return sat_q15(ONE_Q30 - (a <<< 1) - (b <<< 1));
	endfunction

	function automatic q15_t rot_off(input qprod_t pa, input qprod_t pb, input logic op);
		rq_t a;
		rq_t b;
		a = RQ_W'(pa);
		b = RQ_W'(pb);
		if (op == OP_SUB)
			return sat_q15((a <<< 1) - (b <<< 1));
		return sat_q15((a <<< 1) + (b <<< 1));
	endfunction

	function automatic pt_t mul_rt(input q15_t r, input q16_t b);
		return PT_W'(r) * PT_W'(b);
	endfunction

	// three-term sum in Q.31, rounded to Q.16, kept wide
	function automatic tval_t round_t3(input pt_t p0, input pt_t p1, input pt_t p2);
		logic signed [ACC_T_W-1:0] a;
		a = ACC_T_W'(p0) + ACC_T_W'(p1) + ACC_T_W'(p2) + ACC_T_W'(2 ** (FRAC - 1));
		return a[ACC_T_W-1:FRAC];
	endfunction

	function automatic pw_t mul_tr(input tval_t t, input q15_t r);
		return PW_W'(t) * PW_W'(r);
	endfunction

	// three-term sum in Q.31, rounded to Q16.16 and saturated
	function automatic q16_t sat_w3(input pw_t p0, input pw_t p1, input pw_t p2);
		logic signed [ACC_W_W-1:0] a;
		logic signed [SH_W_W-1:0] s;
		a = ACC_W_W'(p0) + ACC_W_W'(p1) + ACC_W_W'(p2) + ACC_W_W'(2 ** (FRAC - 1));
		s = a[ACC_W_W-1:FRAC];
		if (&s[SH_W_W-1:31] || ~|s[SH_W_W-1:31])
			return s[31:0];
		return s[SH_W_W-1] ? Q16_MIN : Q16_MAX;
	endfunction

endpackage

// ===== hw/rtl/rbdd_rot.sv =====
// rbdd_rot: two-stage pipeline from quaternion to saturated Q1.15 rotation matrix
`timescale 1ns / 1ps

module rbdd_rot (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                body_valid,
	output logic                body_ready,
	input  rbdd_pkg::body_t     body,
	output logic                rot_valid,
	input  logic                rot_ready,
	output rbdd_pkg::rot_item_t rot
);

	logic en_s1, en_s2;
	logic valid_s1, valid_s2;

	rbdd_pkg::qprod_t p_xx_s1, p_yy_s1, p_zz_s1;
	rbdd_pkg::qprod_t p_xy_s1, p_xz_s1, p_yz_s1;
	rbdd_pkg::qprod_t p_wx_s1, p_wy_s1, p_wz_s1;
	rbdd_pkg::vec3_t  pos_s1;

	rbdd_pkg::rmat_t  rmat_d, rmat_s2;
	rbdd_pkg::vec3_t  pos_s2;

	assign en_s2      = !valid_s2 || rot_ready;
	assign en_s1      = !valid_s1 || en_s2;
	assign body_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= body_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && body_valid) begin
			p_xx_s1   <= rbdd_pkg::mul_q(body.quat_x, body.quat_x);
			p_yy_s1   <= rbdd_pkg::mul_q(body.quat_y, body.quat_y);
			p_zz_s1   <= rbdd_pkg::mul_q(body.quat_z, body.quat_z);
			p_xy_s1   <= rbdd_pkg::mul_q(body.quat_x, body.quat_y);
			p_xz_s1   <= rbdd_pkg::mul_q(body.quat_x, body.quat_z);
			p_yz_s1   <= rbdd_pkg::mul_q(body.quat_y, body.quat_z);
			p_wx_s1   <= rbdd_pkg::mul_q(body.quat_w, body.quat_x);
			p_wy_s1   <= rbdd_pkg::mul_q(body.quat_w, body.quat_y);
			p_wz_s1   <= rbdd_pkg::mul_q(body.quat_w, body.quat_z);
			pos_s1[0] <= body.pos_x;
			pos_s1[1] <= body.pos_y;
			pos_s1[2] <= body.pos_z;
		end
		if (en_s2 && valid_s1) begin
			rmat_s2 <= rmat_d;
			pos_s2  <= pos_s1;
		end
	end

	always_comb begin
		rmat_d[0][0] = rbdd_pkg::rot_diag(p_yy_s1, p_zz_s1);
		rmat_d[0][1] = rbdd_pkg::rot_off(p_xy_s1, p_wz_s1, rbdd_pkg::OP_SUB);
		rmat_d[0][2] = rbdd_pkg::rot_off(p_xz_s1, p_wy_s1, rbdd_pkg::OP_ADD);
		rmat_d[1][0] = rbdd_pkg::rot_off(p_xy_s1, p_wz_s1, rbdd_pkg::OP_ADD);
		rmat_d[1][1] = rbdd_pkg::rot_diag(p_xx_s1, p_zz_s1);
		rmat_d[1][2] = rbdd_pkg::rot_off(p_yz_s1, p_wx_s1, rbdd_pkg::OP_SUB);
		rmat_d[2][0] = rbdd_pkg::rot_off(p_xz_s1, p_wy_s1, rbdd_pkg::OP_SUB);
		rmat_d[2][1] = rbdd_pkg::rot_off(p_yz_s1, p_wx_s1, rbdd_pkg::OP_ADD);
		rmat_d[2][2] = rbdd_pkg::rot_diag(p_xx_s1, p_yy_s1);
	end

	assign rot_valid = valid_s2;
	assign rot.rmat  = rmat_s2;
	assign rot.pos   = pos_s2;

endmodule

// ===== hw/rtl/rbdd_seq.sv =====
// rbdd_seq: holds one body's rotation matrix and issues its three rows in turn
`timescale 1ns / 1ps
`include "rigid_body_derived_data_defines.svh"

module rbdd_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rot_valid,
	output logic                rot_ready,
	input  rbdd_pkg::rot_item_t rot,
	output logic                job_valid,
	input  logic                job_ready,
	output rbdd_pkg::row_job_t  job
);

	rbdd_pkg::rot_item_t item_q;
	logic                valid_q;
	logic [1:0]          idx_q;
	logic                last;

	assign last = (idx_q == rbdd_pkg::ROW_LAST);
	// next body loads as the last row transfers
	assign rot_ready = !valid_q || (job_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= rbdd_pkg::ROW_FIRST;
		end else if (rot_valid && rot_ready) begin
			valid_q <= 1'b1;
			idx_q   <= rbdd_pkg::ROW_FIRST;
		end else if (valid_q && job_ready) begin
			if (last)
				valid_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (rot_valid && rot_ready)
			item_q <= rot;
	end

	assign job_valid = valid_q;
	assign job.idx   = idx_q;
	assign job.rrow  = item_q.rmat[idx_q];
	assign job.rmat  = item_q.rmat;
	assign job.trans = item_q.pos[idx_q];

	`RBDD_ASSERT_NEXT(a_row_step, valid_q && job_ready && !last, valid_q && (idx_q == $past(idx_q) + 2'd1))
	`RBDD_ASSERT_NEXT(a_load_first, rot_valid && rot_ready, valid_q && (idx_q == rbdd_pkg::ROW_FIRST))
	`RBDD_ASSERT_SAME(a_hold_busy, valid_q && !last, !rot_ready)

endmodule

// ===== hw/rtl/rbdd_row.sv =====
// rbdd_row: four-stage row pipeline, tensor row T = r*Ib then world row W = T*R^T
`timescale 1ns / 1ps
`include "rigid_body_derived_data_defines.svh"

module rbdd_row (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  rbdd_pkg::row_job_t job,
	input  rbdd_pkg::imat_t    ib,
	output logic               row_valid,
	input  logic               row_ready,
	output rbdd_pkg::row_t     row
);

	logic en_s1, en_s2, en_s3, en_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic [1:0]      idx_s1, idx_s2, idx_s3;
	rbdd_pkg::rrow_t rrow_s1, rrow_s2, rrow_s3;
	rbdd_pkg::rmat_t rmat_s1, rmat_s2;
	rbdd_pkg::q16_t  trans_s1, trans_s2, trans_s3;

	rbdd_pkg::pt_t   pt_d [3][3];
	rbdd_pkg::pt_t   pt_s1 [3][3];
	rbdd_pkg::tval_t t_d [3];
	rbdd_pkg::tval_t t_s2 [3];
	rbdd_pkg::pw_t   pw_d [3][3];
	rbdd_pkg::pw_t   pw_s3 [3][3];
	rbdd_pkg::row_t  row_d, row_s4;

	assign en_s4     = !valid_s4 || row_ready;
	assign en_s3     = !valid_s3 || en_s4;
	assign en_s2     = !valid_s2 || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign job_ready = en_s1;

	// pt[j][k] = r[i][k] * Ib[k][j]
	always_comb begin
		for (int j = 0; j < 3; j++)
			for (int k = 0; k < 3; k++)
				pt_d[j][k] = rbdd_pkg::mul_rt(job.rrow[k], ib[k][j]);
	end

	always_comb begin
		for (int j = 0; j < 3; j++)
			t_d[j] = rbdd_pkg::round_t3(pt_s1[j][0], pt_s1[j][1], pt_s1[j][2]);
	end

	// pw[j][k] = T[i][k] * R[j][k], row j of R is column j of R^T
	always_comb begin
		for (int j = 0; j < 3; j++)
			for (int k = 0; k < 3; k++)
				pw_d[j][k] = rbdd_pkg::mul_tr(t_s2[k], rmat_s2[j][k]);
	end

	always_comb begin
		row_d.row_index   = idx_s3;
		row_d.rot_c0      = rrow_s3[0];
		row_d.rot_c1      = rrow_s3[1];
		row_d.rot_c2      = rrow_s3[2];
		row_d.translation = trans_s3;
		row_d.world_c0    = rbdd_pkg::sat_w3(pw_s3[0][0], pw_s3[0][1], pw_s3[0][2]);
		row_d.world_c1    = rbdd_pkg::sat_w3(pw_s3[1][0], pw_s3[1][1], pw_s3[1][2]);
		row_d.world_c2    = rbdd_pkg::sat_w3(pw_s3[2][0], pw_s3[2][1], pw_s3[2][2]);
		row_d.last_row    = (idx_s3 == rbdd_pkg::ROW_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= job_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_s3)
				valid_s3 <= valid_s2;
			if (en_s4)
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && job_valid) begin
			idx_s1   <= job.idx;
			rrow_s1  <= job.rrow;
			rmat_s1  <= job.rmat;
			trans_s1 <= job.trans;
			pt_s1    <= pt_d;
		end
		if (en_s2 && valid_s1) begin
			idx_s2   <= idx_s1;
			rrow_s2  <= rrow_s1;
			rmat_s2  <= rmat_s1;
			trans_s2 <= trans_s1;
			t_s2     <= t_d;
		end
		if (en_s3 && valid_s2) begin
			idx_s3   <= idx_s2;
			rrow_s3  <= rrow_s2;
			trans_s3 <= trans_s2;
			pw_s3    <= pw_d;
		end
		if (en_s4 && valid_s3)
			row_s4 <= row_d;
	end

	assign row_valid = valid_s4;
	assign row       = row_s4;

	`RBDD_ASSERT_NEXT(a_stall_keeps, valid_s4 && !row_ready && valid_s3, valid_s3 && valid_s4)
	`RBDD_ASSERT_SAME(a_last_flag, row_valid, row.last_row == (row.row_index == rbdd_pkg::ROW_LAST))

endmodule

// ===== hw/rtl/rigid_body_derived_data.sv =====
// rigid_body_derived_data: top level, inertia registers and the rotation/row pipelines
`timescale 1ns / 1ps

// Takes a body's orientation quaternion (Q1.15) and position (Q16.16) and returns three
// row transfers per body, rows 0, 1, 2 in order: a row of the rotation matrix R (Q1.15,
// saturated), the matching position component, and a row of the world inverse inertia
// tensor R*Ib*R^T (Q16.16, saturated), with last_row set on row 2. Ib is the symmetric
// body-frame inverse tensor held in six registers written through cfg_wr_en/cfg_index/
// cfg_wdata (indexes 0..5: xx, yy, zz, xy, xz, yz; other indexes are ignored). New bodies
// are taken while earlier ones are in flight when the output keeps up: the row sequencer
// feeds one row a cycle into the row pipeline while it is not stalled, and accepts the
// next body as the last row goes in. A body passes through the two rotation stages, the
// sequencer and the four row stages in turn. No quaternion normalization is done.
module rigid_body_derived_data (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_wdata,
	input  logic            body_valid,
	output logic            body_ready,
	input  rbdd_pkg::body_t body,
	output logic            row_valid,
	input  logic            row_ready,
	output rbdd_pkg::row_t  row
);

	rbdd_pkg::q16_t inv_xx_q, inv_yy_q, inv_zz_q;
	rbdd_pkg::q16_t inv_xy_q, inv_xz_q, inv_yz_q;
	rbdd_pkg::imat_t ib;

	logic                rot_valid, rot_ready;
	rbdd_pkg::rot_item_t rot;
	logic                job_valid, job_ready;
	rbdd_pkg::row_job_t  job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_xx_q <= rbdd_pkg::Q16_ONE;
			inv_yy_q <= rbdd_pkg::Q16_ONE;
			inv_zz_q <= rbdd_pkg::Q16_ONE;
			inv_xy_q <= rbdd_pkg::Q16_ZERO;
			inv_xz_q <= rbdd_pkg::Q16_ZERO;
			inv_yz_q <= rbdd_pkg::Q16_ZERO;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rbdd_pkg::REG_XX: inv_xx_q <= cfg_wdata;
				rbdd_pkg::REG_YY: inv_yy_q <= cfg_wdata;
				rbdd_pkg::REG_ZZ: inv_zz_q <= cfg_wdata;
				rbdd_pkg::REG_XY: inv_xy_q <= cfg_wdata;
				rbdd_pkg::REG_XZ: inv_xz_q <= cfg_wdata;
				rbdd_pkg::REG_YZ: inv_yz_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// symmetric tensor, off-diagonal registers feed both halves
	assign ib[0][0] = inv_xx_q;
	assign ib[1][1] = inv_yy_q;
	assign ib[2][2] = inv_zz_q;
	assign ib[0][1] = inv_xy_q;
	assign ib[1][0] = inv_xy_q;
	assign ib[0][2] = inv_xz_q;
	assign ib[2][0] = inv_xz_q;
	assign ib[1][2] = inv_yz_q;
	assign ib[2][1] = inv_yz_q;

	rbdd_rot u_rot (
		.clk        (clk),
		.arst_n     (arst_n),
		.body_valid (body_valid),
		.body_ready (body_ready),
		.body       (body),
		.rot_valid  (rot_valid),
		.rot_ready  (rot_ready),
		.rot        (rot)
	);

	rbdd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.rot_valid (rot_valid),
		.rot_ready (rot_ready),
		.rot       (rot),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	rbdd_row u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.ib        (ib),
		.row_valid (row_valid),
		.row_ready (row_ready),
		.row       (row)
	);

endmodule

// ===== test/tb_rigid_body_derived_data.sv =====
// testbench for rigid_body_derived_data: rotation and world inverse inertia rows
`timescale 1ns / 1ps

module tb_rigid_body_derived_data;
	import rbdd_pkg::*;

	localparam longint UNIT_Q30 = longint'(1) <<< 30;
	localparam longint Q15_LO = -32768;
	localparam longint Q15_HI = 32767;
	localparam longint Q16_LO = -(longint'(1) <<< 31);
	localparam longint Q16_HI = (longint'(1) <<< 31) - 1;
	localparam logic [2:0] IDX_SPARE_LO = 3'd6;
	localparam logic [2:0] IDX_SPARE_HI = 3'd7;
	localparam shortint HALF_SQRT2 = 23170;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_REPORTS = 20;

	// expected row transfers for accepted bodies, worked out from the quaternion
	class inertia_row_board;
		longint inertia[6];
		row_t rows_due[$];
		int mismatches;
		int rows_checked;
		int bodies_taken;

		function new();
			inertia[REG_XX] = Q16_ONE;
			inertia[REG_YY] = Q16_ONE;
			inertia[REG_ZZ] = Q16_ONE;
			inertia[REG_XY] = Q16_ZERO;
			inertia[REG_XZ] = Q16_ZERO;
			inertia[REG_YZ] = Q16_ZERO;
		endfunction

		// spare indexes leave the tensor unchanged
		function void write_reg(logic [2:0] idx, logic [31:0] val);
			if (idx <= 3'(REG_YZ))
				inertia[idx] = longint'($signed(val));
		endfunction

		function longint round_q15(longint v);
			return (v + (longint'(1) <<< 14)) >>> 15;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void take_body(body_t b);
			longint qw, qx, qy, qz;
			longint rot_q30[3][3];
			longint rot[3][3];
			longint ib[3][3];
			longint tmp[3][3];
			longint wv[3];
			longint pos[3];
			longint acc;
			row_t item;
			qw = b.quat_w;
			qx = b.quat_x;
			qy = b.quat_y;
			qz = b.quat_z;
			pos[0] = b.pos_x;
			pos[1] = b.pos_y;
			pos[2] = b.pos_z;
			rot_q30[0][0] = UNIT_Q30 - 2 * qy * qy - 2 * qz * qz;
			rot_q30[0][1] = 2 * qx * qy - 2 * qw * qz;
			rot_q30[0][2] = 2 * qx * qz + 2 * qw * qy;
			rot_q30[1][0] = 2 * qx * qy + 2 * qw * qz;
			rot_q30[1][1] = UNIT_Q30 - 2 * qx * qx - 2 * qz * qz;
			rot_q30[1][2] = 2 * qy * qz - 2 * qw * qx;
			rot_q30[2][0] = 2 * qx * qz - 2 * qw * qy;
			rot_q30[2][1] = 2 * qy * qz + 2 * qw * qx;
			rot_q30[2][2] = UNIT_Q30 - 2 * qx * qx - 2 * qy * qy;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					rot[i][j] = clamp(round_q15(rot_q30[i][j]), Q15_LO, Q15_HI);
			ib[0][0] = inertia[REG_XX];
			ib[1][1] = inertia[REG_YY];
			ib[2][2] = inertia[REG_ZZ];
			ib[0][1] = inertia[REG_XY];
			ib[1][0] = inertia[REG_XY];
			ib[0][2] = inertia[REG_XZ];
			ib[2][0] = inertia[REG_XZ];
			ib[1][2] = inertia[REG_YZ];
			ib[2][1] = inertia[REG_YZ];
			// intermediate R*Ib is rounded but kept wide
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					acc = 0;
					for (int k = 0; k < 3; k++)
						acc += rot[i][k] * ib[k][j];
					tmp[i][j] = round_q15(acc);
				end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					acc = 0;
					for (int k = 0; k < 3; k++)
						acc += tmp[i][k] * rot[j][k];
					wv[j] = clamp(round_q15(acc), Q16_LO, Q16_HI);
				end
				item.row_index = 2'(i);
				item.rot_c0 = 16'(rot[i][0]);
				item.rot_c1 = 16'(rot[i][1]);
				item.rot_c2 = 16'(rot[i][2]);
				item.translation = 32'(pos[i]);
				item.world_c0 = 32'(wv[0]);
				item.world_c1 = 32'(wv[1]);
				item.world_c2 = 32'(wv[2]);
				item.last_row = (2'(i) == ROW_LAST);
				rows_due.push_back(item);
			end
			bodies_taken++;
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: row %0d %s expected %h got %h", $time, rows_checked,
						field, want, got);
			end
		endfunction

		function void check_row(row_t got);
			row_t want;
			if (rows_due.size() == 0) begin
				mismatches++;
				$display("%0t: row transfer with nothing expected, got %h", $time, got);
				return;
			end
			want = rows_due.pop_front();
			compare("row_index", want.row_index, got.row_index);
			compare("rot_c0", want.rot_c0, got.rot_c0);
			compare("rot_c1", want.rot_c1, got.rot_c1);
			compare("rot_c2", want.rot_c2, got.rot_c2);
			compare("translation", want.translation, got.translation);
			compare("world_c0", want.world_c0, got.world_c0);
			compare("world_c1", want.world_c1, got.world_c1);
			compare("world_c2", want.world_c2, got.world_c2);
			compare("last_row", want.last_row, got.last_row);
			rows_checked++;
		endfunction

		function int pending_count();
			return rows_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [2:0] cfg_index;
	logic [31:0] cfg_wdata;
	logic body_valid;
	logic body_ready;
	body_t body;
	logic row_valid;
	logic row_ready;
	row_t row;

	inertia_row_board sb;
	int tx_idle_pct;
	int rx_stall_pct;
	bit rx_hold;

	rigid_body_derived_data dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.body_valid(body_valid),
		.body_ready(body_ready),
		.body(body),
		.row_valid(row_valid),
		.row_ready(row_ready),
		.row(row)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#(1_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		row_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				rx_hold = 1'b0;
				row_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				row_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && row_valid && row_ready)
			sb.check_row(row);
	end

	function automatic body_t mk_body(shortint w, shortint x, shortint y, shortint z,
			int px, int py, int pz);
		body_t b;
		b.quat_w = w;
		b.quat_x = x;
		b.quat_y = y;
		b.quat_z = z;
		b.pos_x = px;
		b.pos_y = py;
		b.pos_z = pz;
		return b;
	endfunction

	function automatic body_t random_body();
		shortint qv[4];
		int pv[3];
		real qr[4];
		real norm;
		int kind;
		kind = $urandom_range(99);
		norm = 0.0;
		for (int i = 0; i < 4; i++) begin
			qr[i] = real'(int'($urandom_range(65535)) - 32768);
			norm += qr[i] * qr[i];
		end
		norm = $sqrt(norm);
		for (int i = 0; i < 4; i++) begin
			// mostly unit quaternions, then raw words, then corner values
			if (kind < 50 && norm > 1.0)
				qv[i] = shortint'($rtoi(qr[i] * 32767.0 / norm));
			else if (kind < 85)
				qv[i] = shortint'($urandom());
			else begin
				case ($urandom_range(4))
					0: qv[i] = Q15_MAX;
					1: qv[i] = Q15_MIN;
					2: qv[i] = 0;
					3: qv[i] = 1;
					default: qv[i] = -1;
				endcase
			end
		end
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(99) < 80)
				pv[i] = int'($urandom());
			else begin
				case ($urandom_range(4))
					0: pv[i] = Q16_MAX;
					1: pv[i] = Q16_MIN;
					2: pv[i] = Q16_ZERO;
					3: pv[i] = Q16_ONE;
					default: pv[i] = -1;
				endcase
			end
		end
		return mk_body(qv[0], qv[1], qv[2], qv[3], pv[0], pv[1], pv[2]);
	endfunction

	task automatic send_body(input body_t b);
		if ($urandom_range(99) < tx_idle_pct) begin
			body_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		body <= b;
		body_valid <= 1'b1;
		@(posedge clk);
		while (!body_ready) @(posedge clk);
		sb.take_body(b);
	endtask

	task automatic send_random(input int n);
		repeat (n) send_body(random_body());
	endtask

	task automatic load_inertia(input logic [5:0][31:0] vals);
		body_valid <= 1'b0;
		while (sb.pending_count() != 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		for (int i = REG_XX; i <= REG_YZ; i++) begin
			cfg_index <= 3'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.write_reg(3'(i), vals[i]);
		end
		// writes to spare indexes must be dropped
		cfg_index <= IDX_SPARE_LO;
		cfg_wdata <= $urandom();
		@(posedge clk);
		sb.write_reg(IDX_SPARE_LO, cfg_wdata);
		cfg_index <= IDX_SPARE_HI;
		cfg_wdata <= $urandom();
		@(posedge clk);
		sb.write_reg(IDX_SPARE_HI, cfg_wdata);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_directed();
		send_body(mk_body(Q15_MAX, 0, 0, 0, 0, 0, 0));
		send_body(mk_body(Q15_MIN, 0, 0, 0, Q16_MAX, Q16_MIN, 0));
		send_body(mk_body(0, 0, 0, 0, 1, -1, Q16_ONE));
		send_body(mk_body(0, Q15_MAX, 0, 0, Q16_MIN, Q16_MAX, -1));
		send_body(mk_body(0, 0, Q15_MAX, 0, Q16_MAX, Q16_MAX, Q16_MAX));
		send_body(mk_body(0, 0, 0, Q15_MAX, Q16_MIN, Q16_MIN, Q16_MIN));
		send_body(mk_body(0, Q15_MIN, 0, 0, 0, Q16_ONE, 0));
		send_body(mk_body(0, 0, Q15_MIN, 0, -1, 0, 1));
		send_body(mk_body(0, 0, 0, Q15_MIN, 32'h5555_5555, 32'hAAAA_AAAA, 0));
		send_body(mk_body(Q15_MAX, Q15_MAX, Q15_MAX, Q15_MAX, 0, 0, 0));
		send_body(mk_body(Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN, -1, -1, -1));
		send_body(mk_body(HALF_SQRT2, HALF_SQRT2, 0, 0, Q16_ONE, 0, 0));
		send_body(mk_body(HALF_SQRT2, 0, HALF_SQRT2, 0, 0, Q16_ONE, 0));
		send_body(mk_body(HALF_SQRT2, 0, 0, HALF_SQRT2, 0, 0, Q16_ONE));
		send_body(mk_body(-HALF_SQRT2, 0, 0, HALF_SQRT2, Q16_MAX, 0, Q16_MIN));
		send_body(mk_body(16384, 16384, 16384, 16384, 123456, -654321, 7));
		send_body(mk_body(Q15_MAX, Q15_MIN, Q15_MAX, Q15_MIN, Q16_MIN, 0, Q16_MAX));
		send_body(mk_body(1, -1, 1, -1, 1, 1, 1));
	endtask

	initial begin
		logic [5:0][31:0] setting;
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		body_valid = 1'b0;
		body = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset tensor, free flow
		run_directed();
		send_random(40);

		// plausible tensor, sender gaps
		for (int i = REG_XX; i <= REG_ZZ; i++)
			setting[i] = $urandom_range(32'h0004_0000, 32'h0000_4000);
		for (int i = REG_XY; i <= REG_YZ; i++)
			setting[i] = 32'($urandom_range(32'h0001_0000)) - 32'h0000_8000;
		load_inertia(setting);
		tx_idle_pct = 60;
		rx_stall_pct = 0;
		send_random(60);

		// largest entries, receiver stalls
		for (int i = REG_XX; i <= REG_YZ; i++)
			setting[i] = Q16_MAX;
		load_inertia(setting);
		tx_idle_pct = 0;
		rx_stall_pct = 60;
		run_directed();
		send_random(60);

		// most negative entries, light idling on both sides
		for (int i = REG_XX; i <= REG_YZ; i++)
			setting[i] = Q16_MIN;
		load_inertia(setting);
		tx_idle_pct = 8;
		rx_stall_pct = 8;
		send_random(60);

		// diagonal at the top, off-diagonal at the bottom
		for (int i = REG_XX; i <= REG_ZZ; i++)
			setting[i] = Q16_MAX;
		for (int i = REG_XY; i <= REG_YZ; i++)
			setting[i] = Q16_MIN;
		load_inertia(setting);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		run_directed();
		send_random(40);

		// arbitrary words; the long hold-off backs the pipeline up into the input
		for (int i = REG_XX; i <= REG_YZ; i++)
			setting[i] = $urandom();
		load_inertia(setting);
		rx_hold = 1'b1;
		send_random(24);
		tx_idle_pct = 8;
		rx_stall_pct = 8;
		send_random(60);

		body_valid <= 1'b0;
		rx_stall_pct = 0;
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d bodies and %0d row transfers over six inertia tensors",
			sb.bodies_taken, sb.rows_checked);
		$display("flow: free running, sender gaps, receiver stalls, both, one long hold-off");
		if (sb.mismatches == 0 && sb.pending_count() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rbdd_pkg.sv
hw/rtl/rbdd_rot.sv
hw/rtl/rbdd_seq.sv
hw/rtl/rbdd_row.sv
hw/rtl/rigid_body_derived_data.sv
test/tb_rigid_body_derived_data.sv
